[rtl/pmseq_pkg.sv]
// shared types, codes and constants for the playhead mode sequencer
package pmseq_pkg;

	localparam int TIME_FRAC_BITS_DEF = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [15:0] WEIGHT_ONE = 16'd32768;
	localparam logic signed [16:0] FRAME_NONE = -17'sd1;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_RESTART = 2'd1;
	localparam logic [1:0] OP_FORCE = 2'd2;

	localparam logic [1:0] MODE_LOOP = 2'd0;
	localparam logic [1:0] MODE_ONCE = 2'd1;
	localparam logic [1:0] MODE_PINGPONG = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_DURATION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_RATE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_IN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_OUT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NEGLIGIBLE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_IGNORE_CTRL = 3'd7;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] dt_seconds;
		logic [15:0] forced_frame;
		logic [15:0] controller_weight;
		logic        paused;
		logic        stopped;
		logic        set_direction;
	} in_item_t;

	typedef struct packed {
		logic signed [16:0] frame;
		logic [31:0]        play_time;
		logic               reversed_now;
		logic               frame_changed;
		logic               track_started;
		logic               track_finished;
		logic               apply_frame;
		logic [15:0]        weight_now;
		logic [15:0]        blend_weight;
	} out_item_t;

	typedef struct packed {
		logic [15:0] duration_frames;
		logic [9:0]  frame_rate;
		logic [15:0] playback_speed;
		logic [1:0]  play_mode;
		logic [31:0] blend_in_frames;
		logic [31:0] blend_out_frames;
		logic [15:0] idle_weight_floor;
		logic        ignore_controller;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_ADV,
		ST_MOD,
		ST_FIN,
		ST_BSET,
		ST_BDIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic adv;
		logic div_step;
		logic fin;
		logic bset;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic need_mod;
		logic need_blend;
		logic ramp;
		logic div_last;
		logic out_free;
	} dp_stat_t;

endpackage

[rtl/pmseq_ctrl.sv]
// controller state machine sequencing one item through the datapath
module pmseq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pmseq_pkg::dp_stat_t stat,
	output pmseq_pkg::dp_cmd_t  cmd
);
	import pmseq_pkg::*;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_n = ST_MUL1;
			end
			ST_MUL1: state_n = ST_MUL2;
			ST_MUL2: state_n = ST_ADV;
			ST_ADV:  state_n = stat.need_mod ? ST_MOD : ST_FIN;
			ST_MOD: begin
				if (stat.div_last) state_n = ST_FIN;
			end
			ST_FIN:  state_n = stat.need_blend ? ST_BSET : ST_DONE;
			ST_BSET: state_n = stat.ramp ? ST_BDIV : ST_DONE;
			ST_BDIV: begin
				if (stat.div_last) state_n = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_MUL1: cmd.mul1 = 1'b1;
			ST_MUL2: cmd.mul2 = 1'b1;
			ST_ADV:  cmd.adv = 1'b1;
			ST_MOD:  cmd.div_step = 1'b1;
			ST_FIN:  cmd.fin = 1'b1;
			ST_BSET: cmd.bset = 1'b1;
			ST_BDIV: cmd.div_step = 1'b1;
			ST_DONE: cmd.out_load = stat.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

[rtl/pmseq_dp.sv]
// datapath: rate multiplies, time advance, shared radix-2 divider, weights
module pmseq_dp #(
	parameter int TIME_FRAC_BITS = pmseq_pkg::TIME_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pmseq_pkg::cfg_t      cfg,
	input  pmseq_pkg::dp_cmd_t   cmd,
	output pmseq_pkg::dp_stat_t  stat,
	input  pmseq_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output pmseq_pkg::out_item_t out_data
);
	import pmseq_pkg::*;

	localparam int DELTA_W = 18 + TIME_FRAC_BITS;
	localparam int SUM_W = ((DELTA_W > 32) ? DELTA_W : 32) + 1;
	localparam int QW = (TIME_FRAC_BITS < 16) ? 48 - TIME_FRAC_BITS : 32;
	localparam int SH_L = (TIME_FRAC_BITS < 16) ? 16 - TIME_FRAC_BITS : 0;
	localparam int SH_R = (TIME_FRAC_BITS >= 16) ? TIME_FRAC_BITS - 16 : 0;
	localparam int CNT_W = $clog2(SUM_W + 1);
	localparam int BLEND_STEPS = 15;

	in_item_t item_q;
	logic [31:0] p1_q;
	logic [DELTA_W-1:0] delta_q;
	logic [SUM_W-1:0] t_q;
	logic [31:0] time_q;
	logic rev_q;
	logic signed [16:0] frame_q;
	logic changed_q, started_q, finished_q, apply_q;
	logic [15:0] weight_q, blend_q;
	logic [31:0] rem_q, den_q;
	logic [SUM_W-1:0] num_q;
	logic [CNT_W-1:0] cnt_q;
	logic div_blend_q;
	logic out_valid_q;
	out_item_t out_q;

	// common terms
	logic [47:0] dc_wide;
	logic [31:0] dc;
	logic restart, force_frame, frozen;
	logic [41:0] p2;

	always_comb begin
		dc_wide = 48'(cfg.duration_frames) << TIME_FRAC_BITS;
		dc = (|dc_wide[47:32]) ? 32'hFFFF_FFFF : dc_wide[31:0];
		restart = (item_q.op == OP_RESTART);
		force_frame = (item_q.op == OP_FORCE);
		frozen = item_q.stopped || (item_q.paused && !force_frame);
		p2 = 42'(p1_q) * 42'(cfg.frame_rate);
	end

	// advance
	logic [SUM_W-1:0] t_sum, t_adv;
	logic rev_adv, wrap;

	always_comb begin
		t_sum = SUM_W'(time_q) + SUM_W'(delta_q);
		t_adv = t_sum;
		rev_adv = rev_q;
		wrap = 1'b0;
		if (!rev_q) begin
			if (t_sum > SUM_W'(dc)) begin
				case (cfg.play_mode)
					MODE_LOOP: begin
						if (dc == '0) t_adv = '0;
						else wrap = 1'b1;
					end
					MODE_ONCE:     t_adv = SUM_W'(dc);
					MODE_PINGPONG: rev_adv = 1'b1;
					default:       t_adv = t_sum;
				endcase
			end
		end else begin
			if (SUM_W'(delta_q) > SUM_W'(time_q)) begin
				t_adv = '0;
				if (cfg.play_mode == MODE_LOOP) t_adv = SUM_W'(dc);
				else if (cfg.play_mode == MODE_PINGPONG) rev_adv = 1'b0;
			end else begin
				t_adv = SUM_W'(time_q) - SUM_W'(delta_q);
			end
		end
	end

	// finish: forced frame, clamp, frame flags, weight
	logic [SUM_W-1:0] t_f;
	logic [31:0] time_new;
	logic signed [16:0] frame_new;
	logic playing, frame_ok;

	always_comb begin
		t_f = force_frame ? ((SUM_W'(item_q.forced_frame) << TIME_FRAC_BITS) + SUM_W'(1))
			: t_q;
		time_new = (t_f > SUM_W'(dc)) ? dc : t_f[31:0];
		frame_new = 17'(time_new >> TIME_FRAC_BITS);
		playing = weight_q > cfg.idle_weight_floor;
		frame_ok = !frozen || (frame_q != FRAME_NONE);
	end

	// blend setup, in Q16.16
	logic [QW-1:0] tq, dq, tqc;
	logic in_ramp, out_ramp, use_in, use_out;
	logic [31:0] b_num, b_den;

	always_comb begin
		tq = (QW'(time_q) << SH_L) >> SH_R;
		dq = (QW'(dc) << SH_L) >> SH_R;
		in_ramp = tq < QW'(cfg.blend_in_frames);
		out_ramp = ((QW + 1)'(tq) + (QW + 1)'(cfg.blend_out_frames)) > (QW + 1)'(dq);
		tqc = (tq > dq) ? dq : tq;
		use_in = rev_q ? (in_ramp && !out_ramp) : in_ramp;
		use_out = rev_q ? out_ramp : (out_ramp && !in_ramp);
		// numerator stays below the span, so the quotient fits in 15 bits
		b_num = use_in ? 32'(tqc) : 32'(dq - tqc);
		b_den = use_in ? cfg.blend_in_frames : cfg.blend_out_frames;
	end

	// shared restoring divider step
	logic [32:0] rem2;
	logic ge;
	logic [31:0] rem_n;
	logic [SUM_W-1:0] num_n;

	always_comb begin
		rem2 = {rem_q, num_q[SUM_W-1]};
		ge = rem2 >= {1'b0, den_q};
		rem_n = ge ? 32'(rem2 - {1'b0, den_q}) : rem2[31:0];
		num_n = {num_q[SUM_W-2:0], ge};
	end

	always_comb begin
		stat.need_mod = !restart && !frozen && wrap;
		stat.need_blend = !restart && frame_ok && !cfg.ignore_controller && playing
			&& (cfg.blend_in_frames != '0) && (cfg.blend_out_frames != '0);
		stat.ramp = use_in || use_out;
		stat.div_last = (cnt_q == CNT_W'(1));
		stat.out_free = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_data;
		if (cmd.mul1) p1_q <= 32'(item_q.dt_seconds) * 32'(cfg.playback_speed);
		if (cmd.mul2) delta_q <= DELTA_W'(p2 >> (24 - TIME_FRAC_BITS));
		if (cmd.adv) begin
			t_q <= t_adv;
			if (wrap) begin
				rem_q <= '0;
				num_q <= t_sum;
				den_q <= dc;
				cnt_q <= CNT_W'(SUM_W);
				div_blend_q <= 1'b0;
			end
		end
		if (cmd.bset) begin
			rem_q <= b_num;
			num_q <= '0;
			den_q <= b_den;
			cnt_q <= CNT_W'(BLEND_STEPS);
			div_blend_q <= 1'b1;
		end
		if (cmd.div_step) begin
			rem_q <= rem_n;
			num_q <= num_n;
			cnt_q <= cnt_q - CNT_W'(1);
			if (stat.div_last && !div_blend_q) t_q <= SUM_W'(rem_n);
		end
		if (cmd.out_load) begin
			out_q.frame <= frame_q;
			out_q.play_time <= time_q;
			out_q.reversed_now <= rev_q;
			out_q.frame_changed <= changed_q;
			out_q.track_started <= started_q;
			out_q.track_finished <= finished_q;
			out_q.apply_frame <= apply_q;
			out_q.weight_now <= weight_q;
			out_q.blend_weight <= blend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			rev_q <= 1'b0;
			frame_q <= FRAME_NONE;
			weight_q <= '0;
			blend_q <= WEIGHT_ONE;
			changed_q <= 1'b0;
			started_q <= 1'b0;
			finished_q <= 1'b0;
			apply_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				changed_q <= 1'b0;
				started_q <= 1'b0;
				finished_q <= 1'b0;
				apply_q <= 1'b0;
			end
			if (cmd.adv) begin
				if (restart) begin
					rev_q <= item_q.set_direction;
					time_q <= item_q.set_direction ? dc : '0;
				end else if (!frozen) begin
					rev_q <= rev_adv;
				end
			end
			if (cmd.fin && !restart) begin
				if (!frozen) begin
					time_q <= time_new;
					if (frame_new != frame_q) begin
						frame_q <= frame_new;
						changed_q <= 1'b1;
						started_q <= (frame_new == 17'sd0);
						finished_q <= (frame_new == $signed({1'b0, cfg.duration_frames}));
					end
				end
				if (frame_ok) begin
					apply_q <= playing;
					if (!cfg.ignore_controller) begin
						weight_q <= (item_q.controller_weight > WEIGHT_ONE) ? WEIGHT_ONE
							: item_q.controller_weight;
					end
				end
			end
			if (cmd.bset && !stat.ramp) blend_q <= WEIGHT_ONE;
			if (cmd.div_step && stat.div_last && div_blend_q) begin
				blend_q <= 16'(num_n[BLEND_STEPS-1:0]);
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

[rtl/playhead_mode_sequencer_unit.sv]
// a plain tick steps through MUL1, MUL2, ADV, FIN and DONE; DONE loads the output register
// a looping wrap adds one divider step per bit of the advanced sum (35 bits at 16 fraction bits)
// a blend recompute adds the BSET setup, plus 15 divider steps inside a ramp
// one item at a time: the input stalls until the last item's result is loaded into the output register
// reset: time 0, frame -1, forward, weight 0, blend 1.0, registers at defaults
module playhead_mode_sequencer_unit #(
	parameter int TIME_FRAC_BITS = pmseq_pkg::TIME_FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  pmseq_pkg::in_item_t                     in_data,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output pmseq_pkg::out_item_t                    out_data,
	input  logic                                    cfg_we,
	input  logic [pmseq_pkg::CFG_IDX_W-1:0]         cfg_idx,
	input  logic [pmseq_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import pmseq_pkg::*;

	cfg_t cfg_q;
	dp_cmd_t cmd;
	dp_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duration_frames <= '0;
			cfg_q.frame_rate <= 10'd30;
			cfg_q.playback_speed <= 16'd256;
			cfg_q.play_mode <= MODE_LOOP;
			cfg_q.blend_in_frames <= '0;
			cfg_q.blend_out_frames <= '0;
			cfg_q.idle_weight_floor <= '0;
			cfg_q.ignore_controller <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DURATION:    cfg_q.duration_frames <= cfg_data[15:0];
				REG_FRAME_RATE:  cfg_q.frame_rate <= cfg_data[9:0];
				REG_SPEED:       cfg_q.playback_speed <= cfg_data[15:0];
				REG_PLAY_MODE:   cfg_q.play_mode <= cfg_data[1:0];
				REG_BLEND_IN:    cfg_q.blend_in_frames <= cfg_data[31:0];
				REG_BLEND_OUT:   cfg_q.blend_out_frames <= cfg_data[31:0];
				REG_NEGLIGIBLE:  cfg_q.idle_weight_floor <= cfg_data[15:0];
				REG_IGNORE_CTRL: cfg_q.ignore_controller <= cfg_data[0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	pmseq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	pmseq_dp #(
		.TIME_FRAC_BITS (TIME_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef SYNTH
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in progress");

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.weight_now <= WEIGHT_ONE && out_data.blend_weight <= WEIGHT_ONE)
		else $error("weight above full scale");

	a_changed_frame_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_changed |-> out_data.frame != FRAME_NONE)
		else $error("frame change reported with no frame");

	a_start_implies_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.track_started || out_data.track_finished)
		|-> out_data.frame_changed)
		else $error("start or finish flag without a frame change");
`endif

endmodule

[bench/playhead_checker.sv]
// checker: predicts playhead sequencer results and compares transfers
module playhead_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  pmseq_pkg::in_item_t   in_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  pmseq_pkg::out_item_t  out_data,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_idx,
	input  logic [31:0]           cfg_data,
	output int                    fail_count,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import pmseq_pkg::*;

	localparam int FB = TIME_FRAC_BITS_DEF;

	cfg_t cfg;
	logic [31:0] time_acc;
	logic signed [16:0] cur_frame;
	logic rev;
	logic [15:0] weight_held;
	logic [15:0] blend_held;
	out_item_t playhead_q[$];

	assign pending = playhead_q.size();

	function automatic logic [63:0] dur_time();
		logic [63:0] d;
		d = 64'(cfg.duration_frames) << FB;
		return (d > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : d;
	endfunction

	function automatic void recompute_blend();
		logic [63:0] tq, dq, bi, bo, w;
		logic in_ramp, out_ramp;
		tq = 64'(time_acc) >> (FB - 16);
		dq = dur_time() >> (FB - 16);
		bi = 64'(cfg.blend_in_frames);
		bo = 64'(cfg.blend_out_frames);
		in_ramp = tq < bi;
		out_ramp = tq + bo > dq;
		w = 64'd32768;
		if (tq > dq) tq = dq;
		if (!rev) begin
			if (in_ramp) w = (tq * 32768) / bi;
			else if (out_ramp) w = ((dq - tq) * 32768) / bo;
		end else begin
			if (out_ramp) w = ((dq - tq) * 32768) / bo;
			else if (in_ramp) w = (tq * 32768) / bi;
		end
		blend_held = w[15:0];
	endfunction

	function automatic out_item_t advance_playhead(in_item_t it);
		out_item_t r;
		logic [63:0] dc, delta, t;
		logic signed [16:0] nf;
		logic chg, sta, fin, app, playing, forced;
		chg = 0; sta = 0; fin = 0; app = 0;
		dc = dur_time();
		if (it.op == OP_RESTART) begin
			rev = it.set_direction;
			time_acc = rev ? dc[31:0] : 32'd0;
		end else begin
			forced = (it.op == OP_FORCE);
			if (!((!forced && it.paused) || it.stopped)) begin
				delta = (64'(it.dt_seconds) * 64'(cfg.playback_speed) * 64'(cfg.frame_rate))
					>> (24 - FB);
				t = 64'(time_acc);
				if (!rev) begin
					t += delta;
					if (t > dc) begin
						if (cfg.play_mode == MODE_LOOP) t = (dc != 0) ? t % dc : 0;
						else if (cfg.play_mode == MODE_ONCE) t = dc;
						else if (cfg.play_mode == MODE_PINGPONG) rev = 1;
					end
				end else begin
					if (delta > t) begin
						t = 0;
						if (cfg.play_mode == MODE_LOOP) t = dc;
						else if (cfg.play_mode == MODE_PINGPONG) rev = 0;
					end else begin
						t -= delta;
					end
				end
				if (forced) t = (64'(it.forced_frame) << FB) + 1;
				if (t > dc) t = dc;
				time_acc = t[31:0];
				nf = $signed({1'b0, 16'(time_acc >> FB)});
				if (nf != cur_frame) begin
					cur_frame = nf;
					chg = 1;
					sta = (nf == 0);
					fin = (nf[15:0] == cfg.duration_frames);
				end
			end
			if (cur_frame != FRAME_NONE) begin
				playing = weight_held > cfg.idle_weight_floor;
				if (!cfg.ignore_controller) begin
					weight_held = (it.controller_weight > WEIGHT_ONE) ? WEIGHT_ONE
						: it.controller_weight;
					if (playing && cfg.blend_in_frames != 0 && cfg.blend_out_frames != 0)
						recompute_blend();
				end
				app = playing;
			end
		end
		r.frame = cur_frame;
		r.play_time = time_acc;
		r.reversed_now = rev;
		r.frame_changed = chg;
		r.track_started = sta;
		r.track_finished = fin;
		r.apply_frame = app;
		r.weight_now = weight_held;
		r.blend_weight = blend_held;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			cfg <= '{frame_rate: 10'd30, playback_speed: 16'd256, default: '0};
			time_acc <= '0;
			cur_frame <= FRAME_NONE;
			rev <= 0;
			weight_held <= '0;
			blend_held <= WEIGHT_ONE;
			fail_count <= 0;
			playhead_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_DURATION: cfg.duration_frames = cfg_data[15:0];
					REG_FRAME_RATE: cfg.frame_rate = cfg_data[9:0];
					REG_SPEED: cfg.playback_speed = cfg_data[15:0];
					REG_PLAY_MODE: cfg.play_mode = cfg_data[1:0];
					REG_BLEND_IN: cfg.blend_in_frames = cfg_data;
					REG_BLEND_OUT: cfg.blend_out_frames = cfg_data;
					REG_NEGLIGIBLE: cfg.idle_weight_floor = cfg_data[15:0];
					REG_IGNORE_CTRL: cfg.ignore_controller = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				playhead_q.push_back(advance_playhead(in_data));
			if (out_valid && !out_stall) begin
				if (playhead_q.size() == 0) begin
					$error("result transfer with no expectation waiting");
					fail_count++;
				end else begin
					e = playhead_q.pop_front();
					if (out_data.frame !== e.frame) begin
						$error("frame: expected %0d, got %0d", e.frame, out_data.frame);
						fail_count++;
					end
					if (out_data.play_time !== e.play_time) begin
						$error("play_time: expected %h, got %h", e.play_time, out_data.play_time);
						fail_count++;
					end
					if (out_data.reversed_now !== e.reversed_now) begin
						$error("reversed_now: expected %b, got %b", e.reversed_now,
							out_data.reversed_now);
						fail_count++;
					end
					if (out_data.frame_changed !== e.frame_changed) begin
						$error("frame_changed: expected %b, got %b", e.frame_changed,
							out_data.frame_changed);
						fail_count++;
					end
					if (out_data.track_started !== e.track_started) begin
						$error("track_started: expected %b, got %b", e.track_started,
							out_data.track_started);
						fail_count++;
					end
					if (out_data.track_finished !== e.track_finished) begin
						$error("track_finished: expected %b, got %b", e.track_finished,
							out_data.track_finished);
						fail_count++;
					end
					if (out_data.apply_frame !== e.apply_frame) begin
						$error("apply_frame: expected %b, got %b", e.apply_frame,
							out_data.apply_frame);
						fail_count++;
					end
					if (out_data.weight_now !== e.weight_now) begin
						$error("weight_now: expected %0d, got %0d", e.weight_now,
							out_data.weight_now);
						fail_count++;
					end
					if (out_data.blend_weight !== e.blend_weight) begin
						$error("blend_weight: expected %0d, got %0d", e.blend_weight,
							out_data.blend_weight);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

[bench/testbench.sv]
// top of the playhead sequencer bench: stimulus, register phases and verdict
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pmseq_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	int fail_count;
	int pending;
	int quiet_cycles;
	bit calm;

	playhead_mode_sequencer_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	playhead_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver stalls in random bursts
	initial begin
		int n;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 14);
				out_stall <= 1;
				repeat (n) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles <= 0;
		else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > 4000) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// write enable is dropped by the next send_item
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// valid stays up after the transfer until the next item, an idle burst or a drain
	task automatic send_item(input in_item_t it);
		int n;
		cfg_we <= 0;
		if (!calm && $urandom_range(0, 6) == 0) begin
			n = $urandom_range(1, 14);
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
	endtask

	function automatic in_item_t random_tick();
		in_item_t it;
		int r;
		r = $urandom_range(0, 99);
		it.op = (r < 70) ? OP_TICK : (r < 82) ? OP_FORCE : (r < 94) ? OP_RESTART : 2'd3;
		it.dt_seconds = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
		it.forced_frame = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 80));
		it.controller_weight = ($urandom_range(0, 7) == 0) ? 16'($urandom)
			: 16'($urandom_range(0, 32768));
		it.paused = ($urandom_range(0, 9) == 0);
		it.stopped = ($urandom_range(0, 14) == 0);
		it.set_direction = $urandom_range(0, 1);
		return it;
	endfunction

	function automatic in_item_t make_item(logic [1:0] op, logic [15:0] dt, logic [15:0] ff,
			logic [15:0] cw, logic p, logic s, logic d);
		in_item_t it;
		it.op = op; it.dt_seconds = dt; it.forced_frame = ff;
		it.controller_weight = cw; it.paused = p; it.stopped = s; it.set_direction = d;
		return it;
	endfunction

	initial begin
		in_item_t it;
		calm = 0;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_idx = '0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// zero duration at reset values: frame still -1 with a frozen tick, then a running tick
		send_item(make_item(OP_TICK, 16'd0, 16'd0, 16'd100, 1, 0, 0));
		send_item(make_item(OP_TICK, 16'hFFFF, 16'd0, 16'hFFFF, 0, 0, 0));
		drain();
		write_reg(REG_DURATION, 32'd60);
		write_reg(REG_BLEND_IN, 32'h0004_0000);
		write_reg(REG_BLEND_OUT, 32'h0008_0000);
		write_reg(REG_NEGLIGIBLE, 32'd10);
		send_item(make_item(OP_FORCE, 16'd0, 16'd0, 16'd32768, 0, 0, 0));
		send_item(make_item(OP_TICK, 16'd2000, 16'd0, 16'd20000, 0, 0, 0));
		send_item(make_item(OP_TICK, 16'd0, 16'd0, 16'd5, 1, 0, 0));
		send_item(make_item(OP_FORCE, 16'd0, 16'd7, 16'd32768, 1, 0, 0));
		send_item(make_item(OP_FORCE, 16'd0, 16'hFFFF, 16'd32768, 0, 0, 0));
		send_item(make_item(OP_TICK, 16'hFFFF, 16'd0, 16'd32768, 0, 0, 0));
		send_item(make_item(OP_TICK, 16'd500, 16'd0, 16'd32768, 0, 1, 0));
		send_item(make_item(OP_RESTART, 16'd0, 16'd0, 16'd0, 0, 0, 1));
		send_item(make_item(OP_TICK, 16'd3000, 16'd0, 16'd32768, 0, 0, 0));
		send_item(make_item(2'd3, 16'd3000, 16'd0, 16'd32768, 0, 0, 0));
		send_item(make_item(OP_RESTART, 16'd0, 16'd0, 16'd0, 0, 0, 0));
		drain();
		write_reg(REG_PLAY_MODE, MODE_PINGPONG);
		write_reg(REG_FRAME_RATE, 32'd1023);
		write_reg(REG_SPEED, 32'hFFFF);
		send_item(make_item(OP_TICK, 16'd4000, 16'd0, 16'd32768, 0, 0, 0));
		send_item(make_item(OP_TICK, 16'd4000, 16'd0, 16'd32768, 0, 0, 0));
		send_item(make_item(OP_TICK, 16'hFFFF, 16'd0, 16'd32768, 0, 0, 0));
		drain();
		write_reg(REG_PLAY_MODE, MODE_ONCE);
		write_reg(REG_IGNORE_CTRL, 32'd1);
		send_item(make_item(OP_TICK, 16'hFFFF, 16'd0, 16'd1234, 0, 0, 0));
		send_item(make_item(OP_RESTART, 16'd0, 16'd0, 16'd0, 0, 0, 1));
		send_item(make_item(OP_TICK, 16'hFFFF, 16'd0, 16'd1234, 0, 0, 0));
		drain();

		// random phases, each with a fresh register setting
		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 11) calm = 1;
			write_reg(REG_DURATION, (ph == 0) ? 32'd65535 : (ph == 1) ? 32'd0
				: (ph == 2) ? 32'd1 : $urandom_range(2, 200));
			write_reg(REG_FRAME_RATE, (ph == 3) ? 32'd1 : (ph == 4) ? 32'd1023
				: $urandom_range(1, 120));
			write_reg(REG_SPEED, (ph == 5) ? 32'd0 : (ph == 6) ? 32'hFFFF
				: $urandom_range(0, 1024));
			write_reg(REG_PLAY_MODE, (ph == 7) ? 32'd3 : ph % 3);
			write_reg(REG_BLEND_IN, (ph == 8) ? 32'hFFFF_FFFF : (ph % 4 == 1) ? 32'd0
				: $urandom_range(1, 32'h0020_0000));
			write_reg(REG_BLEND_OUT, (ph == 9) ? 32'hFFFF_FFFF : (ph % 5 == 2) ? 32'd0
				: $urandom_range(1, 32'h0020_0000));
			write_reg(REG_NEGLIGIBLE, (ph == 10) ? 32'd32768 : (ph % 3 == 1) ? 32'd0
				: $urandom_range(0, 16'hFFFF));
			write_reg(REG_IGNORE_CTRL, (ph % 6 == 5));
			for (int k = 0; k < 150; k++) begin
				it = random_tick();
				send_item(it);
			end
			drain();
		end

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
